@@ hw/rtl/rotation_matrix_to_quaternion_defines.svh @@
// Assertion macros used by the rotation matrix to quaternion back end
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Implication checked on every clock edge, disabled while in reset
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");

`endif

@@ hw/rtl/rmq_pkg.sv @@
// Types and constants for the rotation matrix to quaternion block
package rmq_pkg;
	localparam int IN_W     = 18;
	localparam int OUT_W    = 18;
	localparam int FRAC     = 16;
	localparam int C_W      = 21;
	localparam int A_W      = 19;
	localparam int SQ_W     = 38;
	localparam int S_W      = 40;
	localparam int W_W      = 62;
	localparam int R_W      = 31;
	localparam int D_W      = 48;
	localparam int Q_W      = 17;
	localparam int HALF_W   = 5;
	localparam int NORM_BASE = W_W - S_W;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W    = $clog2(FIFO_DEPTH);
	localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [C_W-1:0] ONE     = C_W'(1) <<< FRAC;
	localparam logic [Q_W-1:0]        OUT_ONE = Q_W'(1) << FRAC;

	typedef logic signed [C_W-1:0] comp_t;

	// unnormalized quaternion x, y, z, w
	typedef struct packed {
		logic [3:0][C_W-1:0] c;
	} raw_t;
endpackage

@@ hw/rtl/rmq_front.sv @@
// Front end: accepts matrices, picks the Shepperd branch, forms raw quaternion
module rmq_front (
	input  logic                             push,
	output logic                             full,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_z,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_z,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_z,
	input  logic                             fifo_full,
	output logic                             wr,
	output rmq_pkg::raw_t                    wdata
);
	import rmq_pkg::*;

	comp_t m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;

	// sign extend the elements
	always_comb begin
		m00 = comp_t'(row0_x); m01 = comp_t'(row0_y); m02 = comp_t'(row0_z);
		m10 = comp_t'(row1_x); m11 = comp_t'(row1_y); m12 = comp_t'(row1_z);
		m20 = comp_t'(row2_x); m21 = comp_t'(row2_y); m22 = comp_t'(row2_z);
		tr  = m00 + m11 + m22;
	end

	// branch on trace, then on largest diagonal element
	always_comb begin
		if (tr > 0) begin
			wdata.c[0] = m12 - m21;
			wdata.c[1] = m20 - m02;
			wdata.c[2] = m01 - m10;
			wdata.c[3] = tr + ONE;
		end else if (m00 > m11 && m00 > m22) begin
			wdata.c[0] = m00 - m11 - m22 + ONE;
			wdata.c[1] = m10 + m01;
			wdata.c[2] = m20 + m02;
			wdata.c[3] = m12 - m21;
		end else if (m11 > m22) begin
			wdata.c[0] = m10 + m01;
			wdata.c[1] = m11 - m00 - m22 + ONE;
			wdata.c[2] = m21 + m12;
			wdata.c[3] = m20 - m02;
		end else begin
			wdata.c[0] = m20 + m02;
			wdata.c[1] = m12 + m21;
			wdata.c[2] = m22 - m00 - m11 + ONE;
			wdata.c[3] = m01 - m10;
		end
	end

	assign full = fifo_full;
	assign wr   = push && !fifo_full;
endmodule

@@ hw/rtl/rmq_fifo.sv @@
// Short queue between front end and normalization pipeline
module rmq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  rmq_pkg::raw_t wdata,
	output logic          full,
	input  logic          rd,
	output rmq_pkg::raw_t rdata,
	output logic          empty
);
	import rmq_pkg::*;

	raw_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + PTR_W'(1);
			if (rd) rptr_q <= rptr_q + PTR_W'(1);
			if (wr && !rd) cnt_q <= cnt_q + CNT_W'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end
endmodule

@@ hw/rtl/rmq_back.sv @@
// Back end: norm, square root and division pipeline with output register
module rmq_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fifo_empty,
	input  rmq_pkg::raw_t                    rdata,
	output logic                             rd,
	input  logic                             pop,
	output logic                             empty,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_x,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_y,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_z,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_w,
	output logic                             degenerate
);
	import rmq_pkg::*;
	`include "rotation_matrix_to_quaternion_defines.svh"

	localparam int SQ0   = 5;
	localparam int DST   = SQ0 + R_W;
	localparam int DIV0  = DST + 1;
	localparam int NSTG  = DIV0 + Q_W;

	typedef struct packed {
		logic [3:0]            sgn;
		logic [3:0][A_W-1:0]   a;
		logic [3:0][SQ_W-1:0]  sq;
		logic                  degen;
		logic [HALF_W-1:0]     half;
		logic [W_W-1:0]        rem;
		logic [R_W-1:0]        root;
		logic [3:0][D_W-1:0]   d;
		logic [3:0][Q_W-1:0]   q;
	} bk_t;

	bk_t  pipe_s [NSTG];
	bk_t  nxt    [NSTG];
	logic vld_s  [NSTG];
	logic en;
	logic out_v_q;
	logic signed [OUT_W-1:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [OUT_W-1:0] res [4];
	logic degen_q;

	// whole pipeline moves when the output slot frees up
	assign en = !out_v_q || pop;
	assign rd = en && !fifo_empty;

	// first stage: sign and magnitude
	always_comb begin
		comp_t ci, mag;
		nxt[0] = '0;
		for (int i = 0; i < 4; i++) begin
			ci = comp_t'(rdata.c[i]);
			mag = (ci < 0) ? -ci : ci;
			nxt[0].sgn[i] = ci[C_W-1];
			nxt[0].a[i]   = mag[A_W-1:0];
		end
	end

	for (genvar g = 1; g < NSTG; g++) begin : g_stg
		if (g == 1) begin : g_sq
			// squares
			always_comb begin
				nxt[g] = pipe_s[g-1];
				for (int i = 0; i < 4; i++)
					nxt[g].sq[i] = SQ_W'(pipe_s[g-1].a[i]) * SQ_W'(pipe_s[g-1].a[i]);
			end
		end else if (g == 2) begin : g_sum
			// sum of squares, coarse placement
			always_comb begin
				logic [S_W-1:0] s;
				s = '0;
				for (int i = 0; i < 4; i++)
					s = s + S_W'(pipe_s[g-1].sq[i]);
				nxt[g]       = pipe_s[g-1];
				nxt[g].degen = (s == '0);
				nxt[g].rem   = W_W'(s) << NORM_BASE;
				nxt[g].half  = HALF_W'(NORM_BASE / 2);
				nxt[g].root  = '0;
			end
		end else if (g == 3) begin : g_nrm1
			// normalize by even shifts of 32 and 16
			always_comb begin
				nxt[g] = pipe_s[g-1];
				if (nxt[g].rem[W_W-1 -: 32] == '0) begin
					nxt[g].rem  = nxt[g].rem << 32;
					nxt[g].half = nxt[g].half + HALF_W'(16);
				end
				if (nxt[g].rem[W_W-1 -: 16] == '0) begin
					nxt[g].rem  = nxt[g].rem << 16;
					nxt[g].half = nxt[g].half + HALF_W'(8);
				end
			end
		end else if (g == 4) begin : g_nrm2
			// normalize by even shifts of 8, 4 and 2
			always_comb begin
				nxt[g] = pipe_s[g-1];
				if (nxt[g].rem[W_W-1 -: 8] == '0) begin
					nxt[g].rem  = nxt[g].rem << 8;
					nxt[g].half = nxt[g].half + HALF_W'(4);
				end
				if (nxt[g].rem[W_W-1 -: 4] == '0) begin
					nxt[g].rem  = nxt[g].rem << 4;
					nxt[g].half = nxt[g].half + HALF_W'(2);
				end
				if (nxt[g].rem[W_W-1 -: 2] == '0) begin
					nxt[g].rem  = nxt[g].rem << 2;
					nxt[g].half = nxt[g].half + HALF_W'(1);
				end
			end
		end else if (g < DST) begin : g_sqrt
			// one root bit per stage
			localparam int K = R_W - 1 - (g - SQ0);
			always_comb begin
				logic [63:0] trial;
				trial = (64'(pipe_s[g-1].root) << (K + 1)) + (64'd1 << (2 * K));
				nxt[g] = pipe_s[g-1];
				if (64'(pipe_s[g-1].rem) >= trial) begin
					nxt[g].rem  = pipe_s[g-1].rem - trial[W_W-1:0];
					nxt[g].root = pipe_s[g-1].root | (R_W'(1) << K);
				end
			end
		end else if (g == DST) begin : g_dvd
			// scaled dividends with half the divisor for rounding
			always_comb begin
				nxt[g] = pipe_s[g-1];
				for (int i = 0; i < 4; i++) begin
					nxt[g].d[i] = ((D_W'(pipe_s[g-1].a[i]) << pipe_s[g-1].half) << FRAC)
						+ D_W'(pipe_s[g-1].root >> 1);
					nxt[g].q[i] = '0;
				end
			end
		end else begin : g_div
			// one quotient bit per stage, four lanes
			localparam int K = Q_W - 1 - (g - DIV0);
			always_comb begin
				logic [D_W-1:0] dv;
				dv = D_W'(pipe_s[g-1].root) << K;
				nxt[g] = pipe_s[g-1];
				for (int i = 0; i < 4; i++) begin
					if (pipe_s[g-1].d[i] >= dv) begin
						nxt[g].d[i] = pipe_s[g-1].d[i] - dv;
						nxt[g].q[i] = pipe_s[g-1].q[i] | (Q_W'(1) << K);
					end
				end
			end
		end
	end

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NSTG; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !fifo_empty;
			for (int j = 1; j < NSTG; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NSTG; j++) pipe_s[j] <= nxt[j];
		end
	end

	// clamp, sign and degenerate handling
	always_comb begin
		logic [Q_W-1:0]   qq;
		logic [OUT_W-1:0] mag;
		for (int i = 0; i < 4; i++) begin
			qq  = (pipe_s[NSTG-1].q[i] > OUT_ONE) ? OUT_ONE : pipe_s[NSTG-1].q[i];
			mag = OUT_W'(qq);
			if (pipe_s[NSTG-1].degen) res[i] = '0;
			else if (pipe_s[NSTG-1].sgn[i]) res[i] = -mag;
			else res[i] = mag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q    <= res[0];
			qy_q    <= res[1];
			qz_q    <= res[2];
			qw_q    <= res[3];
			degen_q <= pipe_s[NSTG-1].degen;
		end
	end

	assign empty      = !out_v_q;
	assign quat_x     = qx_q;
	assign quat_y     = qy_q;
	assign quat_z     = qz_q;
	assign quat_w     = qw_q;
	assign degenerate = degen_q;

	`RMQ_ASSERT_IMPL(a_degen_zero, !empty && degenerate, quat_x == '0 && quat_w == '0)
	`RMQ_ASSERT_IMPL(a_out_range, !empty, quat_x <= 65536 && quat_x >= -65536)
	`RMQ_ASSERT_IMPL(a_norm_top, vld_s[SQ0-1] && !pipe_s[SQ0-1].degen, pipe_s[SQ0-1].rem[W_W-1 -: 2] != 2'b00)
	`RMQ_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(quat_y))
endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to unit quaternion; one transaction per cycle sustained while
// pop keeps the output slot free.
// The 31-stage square root and the 17-stage restoring division lanes set the latency.
// A 4-entry queue separates branch selection from the normalization pipeline.
// arst_n clears the queue, the pipeline valid bits and the output slot; no other state.
module rotation_matrix_to_quaternion (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row0_z,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row1_z,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_x,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_y,
	input  logic signed [rmq_pkg::IN_W-1:0]  row2_z,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_x,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_y,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_z,
	output logic signed [rmq_pkg::OUT_W-1:0] quat_w,
	output logic                             degenerate
);
	import rmq_pkg::*;

	logic fifo_full, fifo_empty, wr, rd;
	raw_t wdata, rdata;

	rmq_front u_front (
		.push, .full,
		.row0_x, .row0_y, .row0_z,
		.row1_x, .row1_y, .row1_z,
		.row2_x, .row2_y, .row2_z,
		.fifo_full, .wr, .wdata
	);

	rmq_fifo u_fifo (
		.clk, .arst_n, .wr, .wdata, .full(fifo_full),
		.rd, .rdata, .empty(fifo_empty)
	);

	rmq_back u_back (
		.clk, .arst_n, .fifo_empty, .rdata, .rd, .pop, .empty,
		.quat_x, .quat_y, .quat_z, .quat_w, .degenerate
	);
endmodule
